// File: rtl/core/dis_pkg.sv
package dis_pkg;

   localparam int CHANNELS = 4;
   localparam int PIN_W = 4;
   localparam int TIME_W = 32;
   localparam int DEBOUNCE_W = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W = 2;

   localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_WINDOW = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_IDLE = 2'd2;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd3000;
   localparam logic [PIN_W-1:0] IDLE_RESET = 4'hF;

   localparam logic [1:0] STAGE_WAIT_CH0 = 2'd0;
   localparam logic [1:0] STAGE_WAIT_CH1 = 2'd1;
   localparam logic [1:0] STAGE_WAIT_CH2 = 2'd2;

   typedef struct packed {
      logic seq;
      logic timed;
   } match_result_type;

endpackage

// File: rtl/core/dis_req_if.sv
interface dis_req_if;
   logic valid;
   logic ready;
   logic [dis_pkg::PIN_W-1:0] pin_levels;
   logic [dis_pkg::TIME_W-1:0] now_ms;

   modport source (output valid, output pin_levels, output now_ms, input ready);
   modport sink (input valid, input pin_levels, input now_ms, output ready);
endinterface

// File: rtl/core/dis_rsp_if.sv
interface dis_rsp_if;
   logic valid;
   logic ready;
   logic [dis_pkg::PIN_W-1:0] event_mask;
   logic [dis_pkg::PIN_W-1:0] stable_levels;
   logic seq_found;
   logic timed_found;

   modport source (output valid, output event_mask, output stable_levels,
                   output seq_found, output timed_found, input ready);
   modport sink (input valid, input event_mask, input stable_levels,
                 input seq_found, input timed_found, output ready);
endinterface

// File: rtl/core/dis_matcher.sv
module dis_matcher (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic [dis_pkg::CHANNELS-1:0]       event_mask,
   input  logic [dis_pkg::CHANNELS-1:0]       levels,
   input  logic [dis_pkg::TIME_W-1:0]         now_ms,
   input  logic [dis_pkg::TIME_W-1:0]         window_ms,
   output dis_pkg::match_result_type          found
);
   import dis_pkg::*;

   logic [1:0]        stage_ff, stage_in;
   logic              armed_ff, armed_in;
   logic [TIME_W-1:0] armed_time_ff, armed_time_in;
   logic [TIME_W-1:0] since_armed;
   logic              in_window;

   assign since_armed = now_ms - armed_time_ff;
   assign in_window = since_armed <= window_ms;

   always_comb begin
      logic [1:0] stage;
      logic       armed;
      logic       armed_here;
      logic       seq;
      logic       timed;
      stage = stage_ff;
      armed = armed_ff;
      armed_here = 1'b0;
      seq = 1'b0;
      timed = 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (event_mask[i] && !(seq || timed)) begin
            case (stage)
               STAGE_WAIT_CH0: begin
                  if (i == 0 && levels[i]) stage = STAGE_WAIT_CH1;
               end
               STAGE_WAIT_CH1: begin
                  if (i == 1 && levels[i]) stage = STAGE_WAIT_CH2;
               end
               default: begin
                  if (i == 2 && !levels[i]) seq = 1'b1;
               end
            endcase
            if (!armed) begin
               if (i == 0 && levels[i]) begin
                  armed = 1'b1;
                  armed_here = 1'b1;
               end
            end else if (i == 1 && levels[i]) begin
               if (armed_here || in_window) timed = 1'b1;
               else armed = 1'b0;
            end
         end
      end
      if (seq) timed = 1'b0;
      found.seq = seq;
      found.timed = timed;
      if (seq || timed) begin
         stage_in = STAGE_WAIT_CH0;
         armed_in = 1'b0;
         armed_time_in = '0;
      end else begin
         stage_in = stage;
         armed_in = armed;
         armed_time_in = armed_here ? now_ms : armed_time_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= STAGE_WAIT_CH0;
         armed_ff <= 1'b0;
         armed_time_ff <= '0;
      end else if (advance) begin
         stage_ff <= stage_in;
         armed_ff <= armed_in;
         armed_time_ff <= armed_time_in;
      end
   end

`ifndef SYNTHESIS
   a_clear_after_match: assert property (@(posedge clock) disable iff (reset)
      advance && (found.seq || found.timed) |=>
         stage_ff == STAGE_WAIT_CH0 && !armed_ff && armed_time_ff == '0)
      else $error("matcher not cleared after a match");
   a_stage_range: assert property (@(posedge clock) disable iff (reset)
      stage_ff != 2'd3)
      else $error("untimed stage out of range");
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      !(found.seq && found.timed))
      else $error("both matchers reported");
`endif

endmodule

// File: rtl/core/debounced_input_sequence_detector_core.sv
// Debounces four input channels and looks for two event sequences. One sample
// transaction is taken per clock cycle unless rsp.ready stalls a full result; its
// result passes the input register, then the result register. All per-sample
// work, the four debounce compares and the in-order matcher walk, sits between
// those two registers. req.ready follows rsp.ready combinationally when both
// stages are full. Registers: debounce_ms at 0x0, window_ms at 0x4, idle_levels
// at 0x8; writing idle_levels also loads the debounced levels.
module debounced_input_sequence_detector_core (
   input  logic                           clock,
   input  logic                           reset,
   dis_req_if.sink                        req,
   dis_rsp_if.source                      rsp,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [dis_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [dis_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [dis_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import dis_pkg::*;

   logic [DEBOUNCE_W-1:0] debounce_ff;
   logic [TIME_W-1:0]     window_ff;
   logic [PIN_W-1:0]      idle_ff;
   logic                  csr_wr;
   logic [REG_IDX_W-1:0]  csr_idx;

   logic                  in_valid_ff, in_valid_in;
   logic [PIN_W-1:0]      pin_ff;
   logic [TIME_W-1:0]     now_ff;
   logic                  advance;

   logic [CHANNELS-1:0]   stable_ff, stable_in;
   logic [TIME_W-1:0]     last_ff [CHANNELS];
   logic [TIME_W-1:0]     elapsed [CHANNELS];
   logic [CHANNELS-1:0]   pins;
   logic [CHANNELS-1:0]   event_w;
   logic [CHANNELS-1:0]   stable_next;
   match_result_type      found;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PIN_W-1:0]      event_ff, event_in;
   logic [PIN_W-1:0]      stable_out_ff, stable_out_in;
   logic                  seq_ff;
   logic                  timed_ff;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      case (csr_idx)
         REG_DEBOUNCE: csr_prdata = {{(CSR_DATA_W-DEBOUNCE_W){1'b0}}, debounce_ff};
         REG_WINDOW:   csr_prdata = window_ff;
         REG_IDLE:     csr_prdata = {{(CSR_DATA_W-PIN_W){1'b0}}, idle_ff};
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         window_ff <= WINDOW_RESET;
         idle_ff <= IDLE_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_DEBOUNCE: debounce_ff <= csr_pwdata[DEBOUNCE_W-1:0];
            REG_WINDOW:   window_ff <= csr_pwdata[TIME_W-1:0];
            REG_IDLE:     idle_ff <= csr_pwdata[PIN_W-1:0];
            default:      ;
         endcase
      end
   end

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req.valid && req.ready) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req.valid && req.ready) begin
         pin_ff <= req.pin_levels;
         now_ff <= req.now_ms;
      end
   end

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         pins[i] = pin_ff[i];
         elapsed[i] = now_ff - last_ff[i];
         event_w[i] = (stable_ff[i] != pins[i]) &&
                      (elapsed[i] >= {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_ff});
      end
      stable_next = stable_ff ^ event_w;
      stable_in = stable_ff;
      if (csr_wr && csr_idx == REG_IDLE) begin
         for (int i = 0; i < CHANNELS; i++) stable_in[i] = csr_pwdata[i];
      end else if (advance) begin
         stable_in = stable_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= IDLE_RESET[CHANNELS-1:0];
         for (int i = 0; i < CHANNELS; i++) last_ff[i] <= '0;
      end else begin
         stable_ff <= stable_in;
         if (advance) begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (event_w[i]) last_ff[i] <= now_ff;
            end
         end
      end
   end

   dis_matcher u_matcher (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .event_mask (event_w),
      .levels     (pins),
      .now_ms     (now_ff),
      .window_ms  (window_ff),
      .found      (found)
   );

   always_comb begin
      event_in = '0;
      stable_out_in = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         event_in[i] = event_w[i];
         stable_out_in[i] = stable_next[i];
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) rsp_valid_in = 1'b1;
      else if (rsp.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         event_ff <= event_in;
         stable_out_ff <= stable_out_in;
         seq_ff <= found.seq;
         timed_ff <= found.timed;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.event_mask = event_ff;
   assign rsp.stable_levels = stable_out_ff;
   assign rsp.seq_found = seq_ff;
   assign rsp.timed_found = timed_ff;

`ifndef SYNTHESIS
   a_levels_follow_events: assert property (@(posedge clock) disable iff (reset)
      advance |=> (stable_ff ^ $past(stable_ff)) == $past(event_w))
      else $error("debounced levels changed without an event");
   a_stalled_item_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(pin_ff) && $stable(now_ff))
      else $error("stalled input item lost");
   a_stamp_on_event: assert property (@(posedge clock) disable iff (reset)
      advance && event_w[0] |=> last_ff[0] == $past(now_ff))
      else $error("channel 0 change time not recorded");
`endif

endmodule
